[hw/rtl/pld_pkg.sv]
package pld_pkg;

    localparam int NORMAL_FRAC_BITS_DEF = 14;

    localparam int LANES       = 3;
    localparam int COORD_W     = 11;
    localparam int DIFF_W      = 12;
    localparam int NORMAL_W    = 16;
    localparam int COLOR_W     = 9;
    localparam int SUM_W       = 12;
    localparam int D2_W        = 24;
    localparam int DOT_W       = 29;
    localparam int MAG_W       = 27;
    localparam int DQ_W        = 16;
    localparam int FALL_W      = 17;
    localparam int PROD_W      = COLOR_W + FALL_W;
    localparam int NUM_W       = MAG_W + PROD_W;
    localparam int DQ350_W     = 25;
    localparam int SQRT_W      = 32;
    localparam int SQRT_STEPS  = 16;
    localparam int Q_BITS      = 13;
    localparam int CNT_W       = 4;

    localparam logic [D2_W-1:0]    FAR_D2      = 24'd62500;
    localparam logic [FALL_W-1:0]  FALLOFF_Q8  = 17'd89600;
    localparam logic [DQ350_W-1:0] FALLOFF_DEN = 25'd350;
    localparam logic [SUM_W-1:0]   Q_CLAMP     = 12'd4095;
    localparam logic signed [SUM_W+1:0] SUM_MAX = 14'sd2047;
    localparam logic signed [SUM_W+1:0] SUM_MIN = -14'sd2048;

    typedef struct packed {
        logic load;
        logic prod;
        logic sqrt_start;
        logic sqrt_step;
        logic scale;
        logic num;
        logic prep;
        logic div_step;
        logic clear_term;
        logic acc;
        logic emit;
    } pld_cmd_t;

    typedef struct packed {
        logic skip;
        logic last;
        logic out_free;
    } pld_stat_t;

endpackage

[hw/rtl/pld_ctrl.sv]
module pld_ctrl
    import pld_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pld_stat_t stat,
    output pld_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PROD  = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_SCALE = 4'd4;
    localparam logic [3:0] S_NUM   = 4'd5;
    localparam logic [3:0] S_PREP  = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_ACC   = 4'd8;
    localparam logic [3:0] S_EMIT  = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PROD;
                end
            end
            S_PROD: begin
                cmd.prod   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK: begin
                if (stat.skip) begin
                    cmd.clear_term = 1'b1;
                    state_next     = S_ACC;
                end else begin
                    cmd.sqrt_start = 1'b1;
                    cnt_next       = '0;
                    state_next     = S_SQRT;
                end
            end
            S_SQRT: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1)) state_next = S_SCALE;
            end
            S_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = S_NUM;
            end
            S_NUM: begin
                cmd.num    = 1'b1;
                state_next = S_PREP;
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(Q_BITS - 1)) state_next = S_ACC;
            end
            S_ACC: begin
                cmd.acc    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!stat.last) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hw/rtl/pld_datapath.sv]
module pld_datapath
    import pld_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [103:0] s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    input  pld_cmd_t    cmd,
    output pld_stat_t   stat
);

    localparam int DW  = DQ350_W + NORMAL_FRAC_BITS;
    localparam int D2W = DW + 1;
    localparam int NNW = ((DW > NUM_W + 1) ? DW : NUM_W + 1) + 1;
    localparam int CW  = (NNW > D2W + Q_BITS) ? NNW : D2W + Q_BITS;

    logic signed [DIFF_W-1:0]   dx_reg, dy_reg;
    logic signed [NORMAL_W-1:0] nx_reg, ny_reg;
    logic [COLOR_W-1:0]         col_reg [LANES];
    logic                       on_reg, last_reg;
    logic [D2_W-1:0]            d2_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic [SQRT_W-1:0]          op_reg, root_reg, one_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic                       neg_reg;
    logic [PROD_W-1:0]          p_reg [LANES];
    logic [DW-1:0]              den_reg;
    logic [NUM_W-1:0]           num_reg [LANES];
    logic [CW-1:0]              rem_reg [LANES];
    logic [CW-1:0]              dsh_reg;
    logic [Q_BITS-1:0]          q_reg [LANES];
    logic                       ovf_reg [LANES];
    logic signed [SUM_W-1:0]    sum_reg [LANES];
    logic [SUM_W-1:0]           out_reg [LANES];
    logic                       m_tvalid_reg;

    logic signed [COORD_W-1:0] vx, vy, lx, ly;
    logic signed [D2_W-1:0]    d2_full;
    logic signed [DOT_W-1:0]   dot_full;
    logic [SQRT_W:0]           trial;
    logic [DQ_W-1:0]           dq;
    logic [FALL_W-1:0]         fall;
    logic [DQ350_W-1:0]        dq350;
    logic [DOT_W-1:0]          dot_abs;
    logic [NNW-1:0]            n_full [LANES];
    logic [D2W-1:0]            d2w;
    logic [SUM_W-1:0]          qs [LANES];
    logic signed [SUM_W:0]     term [LANES];
    logic signed [SUM_W+1:0]   sacc [LANES];
    logic signed [SUM_W-1:0]   sum_new [LANES];

    assign vx = s_tdata[10:0];
    assign vy = s_tdata[21:11];
    assign lx = s_tdata[64:54];
    assign ly = s_tdata[75:65];

    assign d2_full  = dx_reg * dx_reg + dy_reg * dy_reg;
    assign dot_full = dx_reg * nx_reg + dy_reg * ny_reg;
    assign trial    = {1'b0, root_reg} + {1'b0, one_reg};
    assign dq       = root_reg[DQ_W-1:0];
    assign fall     = FALLOFF_Q8 - FALL_W'(dq);
    assign dq350    = DQ350_W'(dq) * FALLOFF_DEN;
    assign dot_abs  = dot_reg[DOT_W-1] ? DOT_W'(-dot_reg) : DOT_W'(dot_reg);
    assign d2w      = {den_reg, 1'b0};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            n_full[i] = NNW'({num_reg[i], 1'b0}) + NNW'(den_reg);
            qs[i]     = (ovf_reg[i] || q_reg[i] > Q_BITS'(Q_CLAMP)) ?
                        Q_CLAMP : q_reg[i][SUM_W-1:0];
            term[i]   = neg_reg ? -$signed({1'b0, qs[i]}) : $signed({1'b0, qs[i]});
            sacc[i]   = (SUM_W+2)'(sum_reg[i]) + (SUM_W+2)'(term[i]);
            if (sacc[i] > SUM_MAX)      sum_new[i] = SUM_MAX[SUM_W-1:0];
            else if (sacc[i] < SUM_MIN) sum_new[i] = SUM_MIN[SUM_W-1:0];
            else                        sum_new[i] = sacc[i][SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dx_reg     <= DIFF_W'(lx) - DIFF_W'(vx);
            dy_reg     <= DIFF_W'(ly) - DIFF_W'(vy);
            nx_reg     <= s_tdata[37:22];
            ny_reg     <= s_tdata[53:38];
            col_reg[0] <= s_tdata[84:76];
            col_reg[1] <= s_tdata[93:85];
            col_reg[2] <= s_tdata[102:94];
            on_reg     <= s_tuser;
            last_reg   <= s_tlast;
        end
        if (cmd.prod) begin
            d2_reg  <= d2_full;
            dot_reg <= dot_full;
        end
        if (cmd.sqrt_start) begin
            op_reg   <= {d2_reg[15:0], 16'h0};
            root_reg <= '0;
            one_reg  <= SQRT_W'(1) << (SQRT_W - 2);
        end
        if (cmd.sqrt_step) begin
            if ({1'b0, op_reg} >= trial) begin
                op_reg   <= op_reg - trial[SQRT_W-1:0];
                root_reg <= (root_reg >> 1) + one_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
        if (cmd.scale) begin
            mag_reg <= dot_abs[MAG_W-1:0];
            neg_reg <= dot_reg[DOT_W-1];
            den_reg <= {dq350, {NORMAL_FRAC_BITS{1'b0}}};
            for (int i = 0; i < LANES; i++) p_reg[i] <= PROD_W'(col_reg[i]) * PROD_W'(fall);
        end
        if (cmd.num) begin
            for (int i = 0; i < LANES; i++) num_reg[i] <= NUM_W'(mag_reg) * NUM_W'(p_reg[i]);
        end
        if (cmd.prep) begin
            dsh_reg <= CW'(d2w) << (Q_BITS - 1);
            for (int i = 0; i < LANES; i++) begin
                rem_reg[i] <= CW'(n_full[i]);
                q_reg[i]   <= '0;
                ovf_reg[i] <= CW'(n_full[i]) >= (CW'(d2w) << Q_BITS);
            end
        end
        if (cmd.div_step) begin
            dsh_reg <= dsh_reg >> 1;
            for (int i = 0; i < LANES; i++) begin
                if (rem_reg[i] >= dsh_reg) begin
                    rem_reg[i] <= rem_reg[i] - dsh_reg;
                    q_reg[i]   <= {q_reg[i][Q_BITS-2:0], 1'b1};
                end else begin
                    q_reg[i]   <= {q_reg[i][Q_BITS-2:0], 1'b0};
                end
            end
        end
        if (cmd.clear_term) begin
            neg_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                q_reg[i]   <= '0;
                ovf_reg[i] <= 1'b0;
            end
        end
        if (cmd.emit) begin
            for (int i = 0; i < LANES; i++) out_reg[i] <= sum_reg[i];
        end
    end

    // accumulators and output valid are control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) sum_reg[i] <= '0;
        end else begin
            if (cmd.emit)         m_tvalid_reg <= 1'b1;
            else if (m_tready)    m_tvalid_reg <= 1'b0;
            for (int i = 0; i < LANES; i++) begin
                if (cmd.emit)     sum_reg[i] <= '0;
                else if (cmd.acc) sum_reg[i] <= sum_new[i];
            end
        end
    end

    assign stat.skip     = !on_reg || (d2_reg == '0) || (d2_reg >= FAR_D2);
    assign stat.last     = last_reg;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'h0, out_reg[2], out_reg[1], out_reg[0]};

endmodule

[hw/rtl/point_light_diffuse_shading_unit.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_tvalid/s_tready  s_tdata, s_tuser (light_on), s_tlast (last_light)
// m_        out        m_tvalid/m_tready  m_tdata (red, green, blue)
//
// One light term runs through the 16-step square root and the 13-step restoring
// divider (three lanes in parallel) before the next transfer is accepted; a light
// that is off, at distance zero or out of range skips both.
// Reset (aresetn, synchronous, active low) idles the controller, clears the
// sums and drops m_tvalid. A held result does not block new transfers in;
// only a last light holds in its final state until the output register frees up.
module point_light_diffuse_shading_unit
    import pld_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vertex_x, vertex_y, normal_x, normal_y, light_x, light_y,
    // light_red, light_green, light_blue (low bit up), one zero pad bit
    input  logic [103:0] s_tdata,
    // light_on
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red, green, blue (low bit up), four zero pad bits
    output logic [39:0]  m_tdata
);

    pld_cmd_t  cmd;
    pld_stat_t stat;

    // sequence each light term
    pld_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // distance, weight, per-channel divide and saturating accumulate
    pld_datapath #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

[tb/point_light_diffuse_shading_unit_checker.sv]
module point_light_diffuse_shading_unit_checker
    import pld_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [103:0] s_tdata,
    input  logic         s_tuser,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [39:0]  m_tdata,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic signed [SUM_W-1:0] blue;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] red;
    } color_sum_t;

    color_sum_t sums_due[$];
    int         acc_red, acc_green, acc_blue;

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bit_pos;
        root = 0;
        bit_pos = 64'd1 << 62;
        while (bit_pos > n) bit_pos >>= 2;
        while (bit_pos != 0) begin
            if (n >= root + bit_pos) begin
                n -= root + bit_pos;
                root = (root >> 1) + bit_pos;
            end else begin
                root >>= 1;
            end
            bit_pos >>= 2;
        end
        return root;
    endfunction

    // weight * colour, rounded half away from zero
    function automatic longint shade_term(longint dot, longint unsigned col,
                                          longint unsigned dq);
        longint unsigned mag, num, den, q;
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        num = mag * col * (64'd89600 - dq);
        den = (64'd1 << NORMAL_FRAC_BITS_DEF) * 64'd350 * dq;
        q = (num * 2 + den) / (den * 2);
        return (dot < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic int sat_sum(int a, longint b);
        longint s;
        s = a + b;
        if (s > 2047) return 2047;
        if (s < -2048) return -2048;
        return int'(s);
    endfunction

    always @(posedge aclk) begin
        longint vx, vy, nx, ny, lx, ly, dx, dy, dot;
        longint unsigned d2, dq;
        color_sum_t got, want;
        if (!aresetn) begin
            acc_red = 0;
            acc_green = 0;
            acc_blue = 0;
            sums_due.delete();
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                vx = $signed(s_tdata[10:0]);
                vy = $signed(s_tdata[21:11]);
                nx = $signed(s_tdata[37:22]);
                ny = $signed(s_tdata[53:38]);
                lx = $signed(s_tdata[64:54]);
                ly = $signed(s_tdata[75:65]);
                if (s_tuser) begin
                    dx = lx - vx;
                    dy = ly - vy;
                    d2 = dx * dx + dy * dy;
                    // zero distance and far lights add nothing
                    if (d2 != 0 && d2 < 62500) begin
                        dot = dx * nx + dy * ny;
                        dq = int_sqrt(d2 << 16);
                        acc_red = sat_sum(acc_red, shade_term(dot, s_tdata[84:76], dq));
                        acc_green = sat_sum(acc_green, shade_term(dot, s_tdata[93:85], dq));
                        acc_blue = sat_sum(acc_blue, shade_term(dot, s_tdata[102:94], dq));
                    end
                end
                if (s_tlast) begin
                    want.red = acc_red[SUM_W-1:0];
                    want.green = acc_green[SUM_W-1:0];
                    want.blue = acc_blue[SUM_W-1:0];
                    sums_due.push_back(want);
                    acc_red = 0;
                    acc_green = 0;
                    acc_blue = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[35:0];
                if (sums_due.size() == 0) begin
                    $error("unexpected result transfer %h", m_tdata);
                    fail_count++;
                end else begin
                    want = sums_due.pop_front();
                    if (got.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, got.blue);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = sums_due.size();
    end

endmodule

[tb/point_light_diffuse_shading_unit_test.sv]
module point_light_diffuse_shading_unit_test;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // vertex_x, vertex_y, normal_x, normal_y, light_x, light_y,
    // light_red, light_green, light_blue, one zero pad bit
    logic [103:0] s_tdata;
    // light_on
    logic         s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    // red, green, blue, four zero pad bits
    logic [39:0]  m_tdata;
    int           fail_count;
    int           pending_count;
    logic         hold_off;
    int           light_count;

    point_light_diffuse_shading_unit u_dut (.*);

    point_light_diffuse_shading_unit_checker u_checker (.*);

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Receiver: random stall pattern, plus a long hold-off when requested.
    always @(posedge aclk) begin
        if (!aresetn || hold_off)
            m_tready <= 1'b0;
        else if (($urandom_range(0, 199) / 50) % 2 == 0)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
    end

    // Hold off the receiver long enough for the block to fill and stall input.
    initial begin
        hold_off = 1'b0;
        wait (light_count > 300);
        @(posedge aclk);
        hold_off = 1'b1;
        repeat (600) @(posedge aclk);
        hold_off = 1'b0;
    end

    // Drive one light; hold it until the transfer happens.
    task automatic send_light(input logic signed [10:0] vx, input logic signed [10:0] vy,
                              input logic signed [15:0] nx, input logic signed [15:0] ny,
                              input logic signed [10:0] lx, input logic signed [10:0] ly,
                              input logic [8:0] cr, input logic [8:0] cg,
                              input logic [8:0] cb, input logic on, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 8)) : 0;
        if (light_count > 600 && light_count < 700) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, cb, cg, cr, ly, lx, ny, nx, vy, vx};
        s_tuser <= on;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        light_count++;
    endtask

    // Random frame of lights around one vertex.
    task automatic send_frame();
        logic signed [10:0] vx, vy, lx, ly;
        logic signed [15:0] nx, ny;
        logic [8:0] cr, cg, cb;
        int n;
        n = int'($urandom_range(1, 6));
        vx = 11'($urandom_range(0, 1400) - 700);
        vy = 11'($urandom_range(0, 1400) - 700);
        nx = 16'($urandom_range(0, 32768) - 16384);
        ny = 16'($urandom_range(0, 32768) - 16384);
        if ($urandom_range(0, 9) == 0) begin
            nx = 16'($urandom);
            ny = 16'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            lx = 11'(vx + $urandom_range(0, 540) - 270);
            ly = 11'(vy + $urandom_range(0, 540) - 270);
            cr = 9'($urandom_range(0, 256));
            cg = 9'($urandom_range(0, 256));
            cb = 9'($urandom_range(0, 256));
            if ($urandom_range(0, 9) == 0) begin
                cr = 9'($urandom);
                cg = 9'($urandom);
                cb = 9'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                // fully random noise item
                send_light(11'($urandom), 11'($urandom), 16'($urandom), 16'($urandom),
                           11'($urandom), 11'($urandom), 9'($urandom), 9'($urandom),
                           9'($urandom), 1'($urandom), i == n - 1);
            end else begin
                send_light(vx, vy, nx, ny, lx, ly, cr, cg, cb,
                           $urandom_range(0, 6) != 0, i == n - 1);
            end
        end
    endtask

    initial begin
        light_count = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // last light with nothing accumulated
        send_light(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 1'b1);
        // zero distance
        send_light(100, -50, 16384, 0, 100, -50, 256, 256, 256, 1'b1, 1'b1);
        // straight on, near, full white
        send_light(0, 0, 16384, 0, 10, 0, 256, 256, 256, 1'b1, 1'b0);
        // facing away, negative term
        send_light(0, 0, -16384, 0, 10, 0, 256, 128, 0, 1'b1, 1'b1);
        // just inside and just at the far limit
        send_light(0, 0, 0, 16384, 0, 249, 256, 256, 256, 1'b1, 1'b0);
        send_light(0, 0, 0, 16384, 0, 250, 256, 256, 256, 1'b1, 1'b1);
        // light off still emits
        send_light(-1024, -1024, -16384, -16384, 1023, 1023, 256, 256, 256, 1'b0, 1'b1);
        // coordinate and field extremes
        send_light(-1024, 1023, 16384, -16384, -1024, 1023, 0, 0, 0, 1'b1, 1'b1);
        send_light(1023, -1024, -32768, 32767, 1023, -1023, 511, 511, 511, 1'b1, 1'b1);
        // saturate positive, then negative
        for (int i = 0; i < 5; i++)
            send_light(0, 0, 32767, 32767, 1, 1, 511, 511, 511, 1'b1, i == 4);
        for (int i = 0; i < 5; i++)
            send_light(0, 0, -32768, -32768, 1, 1, 511, 300, 511, 1'b1, i == 4);

        while (light_count < 950) send_frame();
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        @(posedge aclk);

        wait (pending_count == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("point_light_diffuse_shading_unit verification clean");
        else
            $display("point_light_diffuse_shading_unit verification failed");
        $finish;
    end

    initial begin
        #40000000;
        $display("point_light_diffuse_shading_unit verification failed");
        $finish;
    end

endmodule
